[design/tftp_receive_sequencer_defines.svh]
// Assertion macros for the TFTP receive sequencer
`ifndef TFTP_RECEIVE_SEQUENCER_DEFINES_SVH
`define TFTP_RECEIVE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define TRS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tftp_receive_sequencer: same-cycle check failed");
`define TRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tftp_receive_sequencer: next-cycle check failed");
`else
`define TRS_ASSERT_SAME(label, clk, rstn, ante, cons)
`define TRS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[design/tftp_rs_pkg.sv]
// Package with types and constants for the TFTP receive sequencer
`timescale 1ns / 1ps

package tftp_rs_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_PACKET = 2'd1,
        CMD_TICK = 2'd2,
        CMD_ABORT = 2'd3
    } cmd_t;

    typedef enum logic {
        PH_IDLE = 1'b0,
        PH_ACTIVE = 1'b1
    } phase_t;

    typedef enum logic [2:0] {
        ST_NONE = 3'd0,
        ST_OK = 3'd1,
        ST_SERVER = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_ABORT = 3'd4
    } status_t;

    localparam logic [15:0] OP_DATA = 16'd3;
    localparam logic [15:0] OP_ERROR = 16'd5;
    localparam logic [9:0] HEADER_LEN = 10'd4;

    localparam logic REG_TIMEOUT_TICKS = 1'b0;
    localparam logic REG_BLOCK_SIZE = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [10:0] BLOCK_SIZE_RESET = 11'd512;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;
    localparam logic [31:0] BYTES_MAX = 32'hFFFF_FFFF;
    localparam logic [7:0] FAULT_MAX = 8'hFF;
    localparam logic [15:0] INITIAL_BLOCK = 16'd1;

endpackage

[design/tftp_receive_sequencer.sv]
// Receive-side TFTP read transfer sequencer: one event in, one result out
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while m_ready takes each result; the critical path
//   is the 32-bit saturating byte add and the block size compare.
// s_ready stays high while the result register is empty or being taken.
// Reset (aresetn low, synchronous): idle session, counters cleared,
//   timeout_ticks 5000, block_size 512, no result pending.
`timescale 1ns / 1ps
`include "tftp_receive_sequencer_defines.svh"

module tftp_receive_sequencer (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [9:0]  s_packet_len,
    input  logic [15:0] s_opcode,
    input  logic [15:0] s_block_number,
    input  logic [15:0] s_source_port,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_send_ack,
    output logic [15:0] m_ack_number,
    output logic [15:0] m_ack_port,
    output logic        m_store_payload,
    output logic [9:0]  m_payload_bytes,
    output logic        m_finished,
    output logic [2:0]  m_status,
    output logic [15:0] m_server_error,
    output logic [31:0] m_total_bytes,
    output logic [15:0] m_total_blocks,
    output logic [7:0]  m_error_count
);

    logic [15:0] timeout_ticks_reg;
    logic [10:0] block_size_reg;

    tftp_rs_pkg::phase_t  phase_reg, phase_next;
    tftp_rs_pkg::status_t last_status_reg, last_status_next;
    logic [15:0] expected_number_reg, expected_number_next;
    logic [15:0] server_port_reg, server_port_next;
    logic        port_latched_reg, port_latched_next;
    logic [31:0] byte_count_reg, byte_count_next;
    logic [15:0] block_count_reg, block_count_next;
    logic [7:0]  fault_count_reg, fault_count_next;
    logic [15:0] wait_timer_reg, wait_timer_next;

    logic        m_valid_reg, m_valid_next;
    logic        send_ack_reg, send_ack_next;
    logic [15:0] ack_number_reg, ack_number_next;
    logic [15:0] ack_port_reg, ack_port_next;
    logic        store_payload_reg, store_payload_next;
    logic [9:0]  payload_bytes_reg, payload_bytes_next;
    logic        finished_reg, finished_next;
    logic [15:0] server_error_reg, server_error_next;

    logic        accept;
    logic [9:0]  payload_len;
    logic [32:0] byte_sum;
    logic [15:0] timer_inc;
    logic [7:0]  fault_inc;
    tftp_rs_pkg::cmd_t cmd;

    logic        finish_idle;
    logic        store_acked;
    logic        ack_open;
    logic        start_taken;
    logic        start_cleared;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;
    assign cmd = tftp_rs_pkg::cmd_t'(s_cmd);

    assign payload_len = s_packet_len - tftp_rs_pkg::HEADER_LEN;
    assign byte_sum = {1'b0, byte_count_reg} + {23'd0, payload_len};
    assign timer_inc = (wait_timer_reg == tftp_rs_pkg::TIMER_MAX) ?
                       tftp_rs_pkg::TIMER_MAX : wait_timer_reg + 16'd1;
    assign fault_inc = (fault_count_reg == tftp_rs_pkg::FAULT_MAX) ?
                       tftp_rs_pkg::FAULT_MAX : fault_count_reg + 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= tftp_rs_pkg::TIMEOUT_RESET;
            block_size_reg <= tftp_rs_pkg::BLOCK_SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tftp_rs_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata;
                tftp_rs_pkg::REG_BLOCK_SIZE: block_size_reg <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next = phase_reg;
        last_status_next = last_status_reg;
        expected_number_next = expected_number_reg;
        server_port_next = server_port_reg;
        port_latched_next = port_latched_reg;
        byte_count_next = byte_count_reg;
        block_count_next = block_count_reg;
        fault_count_next = fault_count_reg;
        wait_timer_next = wait_timer_reg;

        m_valid_next = m_valid_reg && !m_ready;
        send_ack_next = send_ack_reg;
        ack_number_next = ack_number_reg;
        ack_port_next = ack_port_reg;
        store_payload_next = store_payload_reg;
        payload_bytes_next = payload_bytes_reg;
        finished_next = finished_reg;
        server_error_next = server_error_reg;

        if (accept) begin
            m_valid_next = 1'b1;
            send_ack_next = 1'b0;
            ack_number_next = '0;
            ack_port_next = '0;
            store_payload_next = 1'b0;
            payload_bytes_next = '0;
            finished_next = 1'b0;
            server_error_next = '0;

            if (cmd == tftp_rs_pkg::CMD_START) begin
                phase_next = tftp_rs_pkg::PH_ACTIVE;
                last_status_next = tftp_rs_pkg::ST_NONE;
                expected_number_next = tftp_rs_pkg::INITIAL_BLOCK;
                server_port_next = '0;
                port_latched_next = 1'b0;
                byte_count_next = '0;
                block_count_next = '0;
                fault_count_next = '0;
                wait_timer_next = '0;
            end else if (phase_reg == tftp_rs_pkg::PH_ACTIVE) begin
                unique case (cmd)
                    tftp_rs_pkg::CMD_PACKET: begin
                        priority if (s_packet_len < tftp_rs_pkg::HEADER_LEN) begin
                        end else if (s_opcode == tftp_rs_pkg::OP_ERROR) begin
                            server_error_next = s_block_number;
                            fault_count_next = fault_inc;
                            phase_next = tftp_rs_pkg::PH_IDLE;
                            last_status_next = tftp_rs_pkg::ST_SERVER;
                            finished_next = 1'b1;
                        end else if (s_opcode == tftp_rs_pkg::OP_DATA) begin
                            if (!port_latched_reg) begin
                                server_port_next = s_source_port;
                                port_latched_next = 1'b1;
                            end
                            if (s_block_number == expected_number_reg) begin
                                payload_bytes_next = payload_len;
                                store_payload_next = (payload_len != '0);
                                byte_count_next = byte_sum[32] ?
                                                  tftp_rs_pkg::BYTES_MAX : byte_sum[31:0];
                                block_count_next = block_count_reg + 16'd1;
                                send_ack_next = 1'b1;
                                ack_number_next = s_block_number;
                                ack_port_next = port_latched_reg ?
                                                server_port_reg : s_source_port;
                                expected_number_next = expected_number_reg + 16'd1;
                                wait_timer_next = '0;
                                if ({1'b0, payload_len} < block_size_reg) begin
                                    phase_next = tftp_rs_pkg::PH_IDLE;
                                    last_status_next = tftp_rs_pkg::ST_OK;
                                    finished_next = 1'b1;
                                end
                            end
                        end else begin
                        end
                    end
                    tftp_rs_pkg::CMD_TICK: begin
                        wait_timer_next = timer_inc;
                        if (timer_inc >= timeout_ticks_reg) begin
                            fault_count_next = fault_inc;
                            phase_next = tftp_rs_pkg::PH_IDLE;
                            last_status_next = tftp_rs_pkg::ST_TIMEOUT;
                            finished_next = 1'b1;
                        end
                    end
                    tftp_rs_pkg::CMD_ABORT: begin
                        phase_next = tftp_rs_pkg::PH_IDLE;
                        last_status_next = tftp_rs_pkg::ST_ABORT;
                        finished_next = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tftp_rs_pkg::PH_IDLE;
            last_status_reg <= tftp_rs_pkg::ST_NONE;
            expected_number_reg <= tftp_rs_pkg::INITIAL_BLOCK;
            server_port_reg <= '0;
            port_latched_reg <= 1'b0;
            byte_count_reg <= '0;
            block_count_reg <= '0;
            fault_count_reg <= '0;
            wait_timer_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            last_status_reg <= last_status_next;
            expected_number_reg <= expected_number_next;
            server_port_reg <= server_port_next;
            port_latched_reg <= port_latched_next;
            byte_count_reg <= byte_count_next;
            block_count_reg <= block_count_next;
            fault_count_reg <= fault_count_next;
            wait_timer_reg <= wait_timer_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        send_ack_reg <= send_ack_next;
        ack_number_reg <= ack_number_next;
        ack_port_reg <= ack_port_next;
        store_payload_reg <= store_payload_next;
        payload_bytes_reg <= payload_bytes_next;
        finished_reg <= finished_next;
        server_error_reg <= server_error_next;
    end

    assign m_valid = m_valid_reg;
    assign m_send_ack = send_ack_reg;
    assign m_ack_number = ack_number_reg;
    assign m_ack_port = ack_port_reg;
    assign m_store_payload = store_payload_reg;
    assign m_payload_bytes = payload_bytes_reg;
    assign m_finished = finished_reg;
    assign m_status = last_status_reg;
    assign m_server_error = server_error_reg;
    assign m_total_bytes = byte_count_reg;
    assign m_total_blocks = block_count_reg;
    assign m_error_count = fault_count_reg;

    assign finish_idle = (m_status != tftp_rs_pkg::ST_NONE) &&
                         (phase_reg == tftp_rs_pkg::PH_IDLE);
    assign store_acked = m_send_ack && (m_payload_bytes != '0);
    assign ack_open = (phase_reg == tftp_rs_pkg::PH_ACTIVE) && port_latched_reg;
    assign start_taken = accept && (cmd == tftp_rs_pkg::CMD_START);
    assign start_cleared = m_valid && (m_status == tftp_rs_pkg::ST_NONE) &&
                           (m_total_bytes == '0) && (m_error_count == '0);

    `TRS_ASSERT_SAME(a_finish_has_status, aclk, aresetn, m_valid && m_finished, finish_idle)
    `TRS_ASSERT_SAME(a_store_needs_ack, aclk, aresetn, m_valid && m_store_payload, store_acked)
    `TRS_ASSERT_SAME(a_ack_while_open, aclk, aresetn, m_valid && m_send_ack && !m_finished, ack_open)
    `TRS_ASSERT_NEXT(a_start_clears, aclk, aresetn, start_taken, start_cleared)

endmodule
